// ===== hw/rtl/psa_pkg.sv =====
// psa_pkg: shared types and constants of the paged slot allocator
// no dependencies; used by the interfaces, the controller, the datapath and the top level
`timescale 1ns / 1ps

package psa_pkg;

    // request and result field widths
    localparam int PAGE_W   = 6;
    localparam int SLOT_W   = 8;
    localparam int STATUS_W = 3;

    // configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 9;
    localparam logic [CFG_DATA_W-1:0] SPP_RESET = 9'd256;
    localparam logic [CFG_DATA_W-1:0] RSV_RESET = 9'd0;

    // register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SLOTS_PER_PAGE = 2'd0,
        REG_RESERVED_SLOTS = 2'd1
    } cfg_reg_t;

    // request kinds
    typedef enum logic {
        REQ_ALLOC = 1'b0,
        REQ_FREE  = 1'b1
    } req_kind_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_DONE     = 3'd0,
        ST_WAS_FREE = 3'd1,
        ST_NO_PAGE  = 3'd2,
        ST_BAD_SLOT = 3'd3,
        ST_FULL     = 3'd4
    } status_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic check;
        logic read;
        logic mask;
        logic pick;
        logic free_upd;
        logic put;
    } psa_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic is_free;
        logic need_read;
        logic pick_more;
        logic out_free;
    } psa_stat_t;

endpackage

// ===== hw/rtl/psa_if.sv =====
// psa_req_if and psa_rsp_if: valid/ready channels for requests and results
// depends on psa_pkg for field widths
`timescale 1ns / 1ps

interface psa_req_if;
    logic                        valid;
    logic                        ready;
    logic                        req_type;
    logic [psa_pkg::PAGE_W-1:0]  page_number;
    logic [psa_pkg::SLOT_W-1:0]  slot_number;

    modport source (output valid, output req_type, output page_number,
                    output slot_number, input ready);
    modport sink   (input valid, input req_type, input page_number,
                    input slot_number, output ready);
endinterface

interface psa_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [psa_pkg::PAGE_W-1:0]    result_page;
    logic [psa_pkg::SLOT_W-1:0]    result_slot;
    logic [psa_pkg::STATUS_W-1:0]  status;

    modport source (output valid, output result_page, output result_slot,
                    output status, input ready);
    modport sink   (input valid, input result_page, input result_slot,
                    input status, output ready);
endinterface

// ===== hw/rtl/psa_ctrl.sv =====
// psa_ctrl: request sequencer of the paged slot allocator
// depends on psa_pkg for the command and status structs
`timescale 1ns / 1ps

module psa_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  psa_pkg::psa_stat_t  stat,
    output psa_pkg::psa_cmd_t   cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_READ,
        S_MASK,
        S_PICK,
        S_FREE,
        S_PUT
    } state_t;

    state_t state_reg;
    state_t state_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (in_valid) state_next = S_CHECK;
            S_CHECK: state_next = stat.need_read ? S_READ : S_PUT;
            S_READ:  state_next = stat.is_free ? S_FREE : S_MASK;
            S_MASK:  state_next = S_PICK;
            S_PICK:  state_next = stat.pick_more ? S_READ : S_PUT;
            S_FREE:  state_next = S_PUT;
            S_PUT:   if (stat.out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // command decode
    always_comb
    begin
        cmd          = '0;
        cmd.load     = (state_reg == S_IDLE) && in_valid;
        cmd.check    = (state_reg == S_CHECK);
        cmd.read     = (state_reg == S_READ);
        cmd.mask     = (state_reg == S_MASK);
        cmd.pick     = (state_reg == S_PICK);
        cmd.free_upd = (state_reg == S_FREE);
        cmd.put      = (state_reg == S_PUT) && stat.out_free;
    end

    assign in_ready = (state_reg == S_IDLE);

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hw/rtl/psa_dpath.sv =====
// psa_dpath: bitmap memory, configuration, page count and result register
// depends on psa_pkg and psa_if; driven by psa_ctrl commands
`timescale 1ns / 1ps

module psa_dpath #(
    parameter int MAX_PAGES = 64,
    parameter int MAX_SLOTS = 256
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [psa_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [psa_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                              in_req_type,
    input  logic [psa_pkg::PAGE_W-1:0]        in_page,
    input  logic [psa_pkg::SLOT_W-1:0]        in_slot,
    input  psa_pkg::psa_cmd_t                 cmd,
    output psa_pkg::psa_stat_t                stat,
    psa_rsp_if.source                         rsp
);

    localparam int SW  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int PW  = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int PCW = $clog2(MAX_PAGES + 1);
    localparam int NW  = $clog2(MAX_SLOTS + 1);

    // configuration and control state
    logic [psa_pkg::CFG_DATA_W-1:0] spp_reg;
    logic [psa_pkg::CFG_DATA_W-1:0] rsv_reg;
    logic [PCW-1:0]                 pages_reg;
    logic                           p0_written_reg;
    logic                           out_valid_reg;

    // request and scan payload
    logic                           req_type_reg;
    logic [psa_pkg::PAGE_W-1:0]     page_reg;
    logic [psa_pkg::SLOT_W-1:0]     slot_reg;
    logic [PW-1:0]                  scan_pg_reg;
    logic [MAX_SLOTS-1:0]           mem_q_reg;
    logic                           rd_valid_reg;
    logic [MAX_SLOTS-1:0]           free_vec_reg;
    logic                           any_free_reg;
    logic [psa_pkg::PAGE_W-1:0]     res_page_reg;
    logic [psa_pkg::SLOT_W-1:0]     res_slot_reg;
    psa_pkg::status_t               res_status_reg;
    logic [psa_pkg::PAGE_W-1:0]     out_page_reg;
    logic [psa_pkg::SLOT_W-1:0]     out_slot_reg;
    psa_pkg::status_t               out_status_reg;

    // bitmap memory, one row per page
    logic [MAX_SLOTS-1:0]           mem [MAX_PAGES];

    logic [NW-1:0]                  n_use;
    logic                           is_free;
    logic                           bad_page;
    logic                           bad_slot;
    logic                           more_pages;
    logic                           can_append;
    logic [PW-1:0]                  rd_addr;
    logic                           rd_valid_next;
    logic [MAX_SLOTS-1:0]           row;
    logic [MAX_SLOTS-1:0]           free_vec_next;
    logic [MAX_SLOTS-1:0]           lowest;
    logic [SW-1:0]                  pick_idx;
    logic [SW-1:0]                  free_idx;
    logic                           free_reserved;
    logic                           free_hit;
    logic                           mem_we;
    logic [PW-1:0]                  mem_wa;
    logic [MAX_SLOTS-1:0]           mem_wd;

    // usable slots per page, clamped to the row width
    always_comb
    begin
        if (32'(spp_reg) > 32'(MAX_SLOTS))
            n_use = NW'(MAX_SLOTS);
        else
            n_use = NW'(spp_reg);
    end

    // request checks
    assign is_free    = (req_type_reg == psa_pkg::REQ_FREE);
    assign bad_page   = !(32'(page_reg) < 32'(pages_reg));
    assign bad_slot   = (32'(slot_reg) >= 32'(n_use));
    assign more_pages = ((32'(scan_pg_reg) + 32'd1) < 32'(pages_reg));
    assign can_append = (32'(pages_reg) < 32'(MAX_PAGES));

    assign stat.is_free   = is_free;
    assign stat.need_read = is_free ? (!bad_page && !bad_slot) : (n_use != '0);
    assign stat.pick_more = !any_free_reg && more_pages;
    assign stat.out_free  = !out_valid_reg || rsp.ready;

    // read address and row validity; a row never written reads as all free
    assign rd_addr = is_free ? PW'(page_reg) : scan_pg_reg;
    assign rd_valid_next = (rd_addr == '0) ? p0_written_reg
                                           : (32'(rd_addr) < 32'(pages_reg));
    assign row = rd_valid_reg ? mem_q_reg : '0;

    // free slots of the scanned row: unused, in range, not reserved
    always_comb
    begin
        for (int i = 0; i < MAX_SLOTS; i++)
        begin
            free_vec_next[i] = !row[i] && (32'(i) < 32'(n_use))
                               && !((scan_pg_reg == '0) && (32'(i) < 32'(rsv_reg)));
        end
    end

    // first free slot: isolate lowest set bit, then encode
    assign lowest = free_vec_reg & (~free_vec_reg + {{(MAX_SLOTS-1){1'b0}}, 1'b1});

    always_comb
    begin
        pick_idx = '0;
        for (int i = 0; i < MAX_SLOTS; i++)
        begin
            if (lowest[i])
                pick_idx = pick_idx | SW'(i);
        end
    end

    // free request decision
    assign free_idx      = SW'(slot_reg);
    assign free_reserved = (page_reg == '0) && (32'(slot_reg) < 32'(rsv_reg));
    assign free_hit      = row[free_idx] && !free_reserved;

    // memory write select
    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = scan_pg_reg;
        mem_wd = row | lowest;
        if (cmd.pick)
        begin
            if (any_free_reg)
            begin
                mem_we = 1'b1;
            end
            else if (!more_pages && can_append)
            begin
                mem_we = 1'b1;
                mem_wa = PW'(pages_reg);
                mem_wd = {{(MAX_SLOTS-1){1'b0}}, 1'b1};
            end
        end
        else if (cmd.free_upd && free_hit)
        begin
            mem_we = 1'b1;
            mem_wa = PW'(page_reg);
            mem_wd = row & ~(MAX_SLOTS'(1) << free_idx);
        end
    end

    // bitmap memory port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        if (cmd.read)
            mem_q_reg <= mem[rd_addr];
    end

    // configuration, page count and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spp_reg        <= psa_pkg::SPP_RESET;
            rsv_reg        <= psa_pkg::RSV_RESET;
            pages_reg      <= PCW'(1);
            p0_written_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    psa_pkg::REG_SLOTS_PER_PAGE: spp_reg <= cfg_wdata;
                    psa_pkg::REG_RESERVED_SLOTS: rsv_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (cmd.pick && !any_free_reg && !more_pages && can_append)
                pages_reg <= pages_reg + PCW'(1);
            if (mem_we && (mem_wa == '0))
                p0_written_reg <= 1'b1;
            if (cmd.put)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // request, scan and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_type_reg <= in_req_type;
            page_reg     <= in_page;
            slot_reg     <= in_slot;
        end
        if (cmd.check)
        begin
            scan_pg_reg <= '0;
            if (is_free)
            begin
                res_page_reg   <= page_reg;
                res_slot_reg   <= slot_reg;
                res_status_reg <= bad_page ? psa_pkg::ST_NO_PAGE : psa_pkg::ST_BAD_SLOT;
            end
            else
            begin
                res_page_reg   <= '0;
                res_slot_reg   <= '0;
                res_status_reg <= psa_pkg::ST_FULL;
            end
        end
        if (cmd.read)
            rd_valid_reg <= rd_valid_next;
        if (cmd.mask)
        begin
            free_vec_reg <= free_vec_next;
            any_free_reg <= |free_vec_next;
        end
        if (cmd.pick)
        begin
            if (any_free_reg)
            begin
                res_page_reg   <= psa_pkg::PAGE_W'(scan_pg_reg);
                res_slot_reg   <= psa_pkg::SLOT_W'(pick_idx);
                res_status_reg <= psa_pkg::ST_DONE;
            end
            else if (more_pages)
            begin
                scan_pg_reg <= scan_pg_reg + PW'(1);
            end
            else if (can_append)
            begin
                res_page_reg   <= psa_pkg::PAGE_W'(pages_reg);
                res_slot_reg   <= '0;
                res_status_reg <= psa_pkg::ST_DONE;
            end
            else
            begin
                res_page_reg   <= '0;
                res_slot_reg   <= '0;
                res_status_reg <= psa_pkg::ST_FULL;
            end
        end
        if (cmd.free_upd)
        begin
            res_page_reg   <= page_reg;
            res_slot_reg   <= slot_reg;
            res_status_reg <= free_hit ? psa_pkg::ST_DONE : psa_pkg::ST_WAS_FREE;
        end
        if (cmd.put)
        begin
            out_page_reg   <= res_page_reg;
            out_slot_reg   <= res_slot_reg;
            out_status_reg <= res_status_reg;
        end
    end

    // result channel
    assign rsp.valid       = out_valid_reg;
    assign rsp.result_page = out_page_reg;
    assign rsp.result_slot = out_slot_reg;
    assign rsp.status      = out_status_reg;

endmodule

// ===== hw/rtl/paged_slot_allocator_top.sv =====
// paged_slot_allocator_top: top level of the paged slot allocator
// depends on psa_pkg, psa_if, psa_ctrl and psa_dpath
`timescale 1ns / 1ps

// The block keeps one used bit per slot for up to MAX_PAGES pages of
// MAX_SLOTS slots, stored as one memory row per page, and answers one
// request at a time with one result. An allocate scans pages in turn
// (read the page row, build the free mask, pick the first free slot), a
// free reads its page row, and a request settled by its checks skips
// the memory. The single read port of the bitmap memory, one page row per
// pass, sets the allocate time. No clearing pass runs after reset: rows of
// pages not yet in use read as all free. Configuration registers are
// written through cfg_we, cfg_index and cfg_wdata while no request is in
// flight; the user must keep to this, as the block does not enforce it.

module paged_slot_allocator_top #(
    parameter int MAX_PAGES = 64,
    parameter int MAX_SLOTS = 256
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [psa_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [psa_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    psa_req_if.sink                          req,
    psa_rsp_if.source                        rsp
);

    psa_pkg::psa_cmd_t  cmd;
    psa_pkg::psa_stat_t stat;
    logic               in_ready;

    // sequencer
    psa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // bitmap and result datapath
    psa_dpath #(
        .MAX_PAGES (MAX_PAGES),
        .MAX_SLOTS (MAX_SLOTS)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .in_req_type (req.req_type),
        .in_page     (req.page_number),
        .in_slot     (req.slot_number),
        .cmd         (cmd),
        .stat        (stat),
        .rsp         (rsp)
    );

    assign req.ready = in_ready;

endmodule

// ===== hw/rtl/psa_checker.sv =====
// psa_checker: port-level assertions for the paged slot allocator
// depends on psa_pkg; bound to paged_slot_allocator_top
`timescale 1ns / 1ps

module psa_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           req_valid,
    input logic                           req_ready,
    input logic                           rsp_valid,
    input logic                           rsp_ready,
    input logic [psa_pkg::PAGE_W-1:0]     rsp_page,
    input logic [psa_pkg::SLOT_W-1:0]     rsp_slot,
    input logic [psa_pkg::STATUS_W-1:0]   rsp_status
);

    // a result waiting on the sink stays offered
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result dropped while stalled");

    // one request in flight: no accept in the cycle after an accept
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while another is in flight");

    // a full store reports page 0 slot 0
    a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == psa_pkg::ST_FULL) |->
            (rsp_page == '0) && (rsp_slot == '0))
        else $error("full result carries a slot");

    // only defined status codes leave the block
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_status <= psa_pkg::ST_FULL))
        else $error("undefined status code");

endmodule

bind paged_slot_allocator_top psa_checker u_psa_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_page   (rsp.result_page),
    .rsp_slot   (rsp.result_slot),
    .rsp_status (rsp.status)
);
